### rtl/io_interrupt_timer_controller_core_defines.svh
// assertion macros used by the interrupt and timer controller checker
`ifndef IO_INTERRUPT_TIMER_CONTROLLER_CORE_DEFINES_SVH
`define IO_INTERRUPT_TIMER_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define IITC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iitc check failed: label");

// next-cycle implication, quiet while reset is high
`define IITC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iitc check failed: label");

`endif

### rtl/iitc_pkg.sv
// shared types, register map and constants of the interrupt and timer controller
package iitc_pkg;

  // default configuration
  localparam int DEF_COUNTER_COUNT = 4;
  localparam int DEF_COUNTER_BITS  = 16;
  localparam int BUS_COUNTER_BITS  = 16;

  // opcodes
  localparam logic [2:0] OP_READ  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_TICK  = 3'd2;
  localparam logic [2:0] OP_PIN   = 3'd3;
  localparam logic [2:0] OP_POWER = 3'd4;
  localparam logic [2:0] OP_RX    = 3'd5;

  // register indexes (reg_offset bits 6:2)
  localparam logic [4:0] REG_CTRL        = 5'd0;
  localparam logic [4:0] REG_SERIAL      = 5'd1;
  localparam logic [4:0] REG_IRQA_STATUS = 5'd4;
  localparam logic [4:0] REG_IRQA_REQ    = 5'd5;
  localparam logic [4:0] REG_IRQA_MASK   = 5'd6;
  localparam logic [4:0] REG_IRQB_STATUS = 5'd8;
  localparam logic [4:0] REG_IRQB_REQ    = 5'd9;
  localparam logic [4:0] REG_IRQB_MASK   = 5'd10;
  localparam logic [4:0] REG_FIRQ_STATUS = 5'd12;
  localparam logic [4:0] REG_FIRQ_REQ    = 5'd13;
  localparam logic [4:0] REG_FIRQ_MASK   = 5'd14;
  localparam logic [4:0] REG_CNT_FIRST   = 5'd16;
  localparam logic [4:0] REG_CNT_LAST    = 5'd31;

  // counter sub-registers
  localparam logic [1:0] CNT_LOW   = 2'd0;
  localparam logic [1:0] CNT_HIGH  = 2'd1;
  localparam logic [1:0] CNT_GO    = 2'd2;
  localparam logic [1:0] CNT_LATCH = 2'd3;

  // pin selects
  localparam logic [4:0] PIN_IL0 = 5'd0;
  localparam logic [4:0] PIN_IL1 = 5'd1;
  localparam logic [4:0] PIN_IL5 = 5'd5;
  localparam logic [4:0] PIN_IL6 = 5'd6;
  localparam logic [4:0] PIN_IL7 = 5'd7;
  localparam logic [4:0] PIN_FH0 = 5'd8;
  localparam logic [4:0] PIN_FH1 = 5'd9;
  localparam logic [4:0] PIN_FL  = 5'd10;
  localparam logic [4:0] PIN_C0  = 5'd11;
  localparam logic [4:0] PIN_C5  = 5'd16;

  // irq and firq bit positions
  localparam int IRQ_POWER  = 4;
  localparam int IRQ_TIMER0 = 5;
  localparam int IRQ_TIMER1 = 6;
  localparam int IRQ_IL0    = 8;
  localparam int IRQ_TX     = 14;
  localparam int IRQ_RX     = 15;
  localparam int FIRQ_FL    = 2;
  localparam int FIRQ_IL0   = 6;

  // masks
  localparam logic [7:0] IRQ_ALWAYS   = 8'h80;
  localparam logic [7:0] IRQ_LATCHED  = 8'h7C;
  localparam logic [5:0] CTRL_BITS    = 6'h3F;
  localparam logic [7:0] CTRL_FIRQ    = 8'h38;
  localparam logic [7:0] CTRL_IRQ_SRC = 8'h0C;

  typedef struct packed {
    logic [2:0] opcode;
    logic [6:0] reg_offset;
    logic [7:0] write_data;
    logic [4:0] pin_select;
    logic       pin_level;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic       firq_line;
    logic [5:0] control_pins_out;
    logic       tx_valid;
    logic [7:0] tx_byte;
  } result_t;

endpackage

### rtl/iitc_in_stage.sv
// input register stage: holds one accepted item until the execute step takes it
module iitc_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  iitc_pkg::item_t item,
  input  logic           advance,
  output logic           fire,
  output iitc_pkg::item_t item_q
);

  logic held;

  // accept when empty or when the held item moves on this cycle
  assign item_ready = !rst && (!held || advance);
  assign fire       = held && advance;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (item_valid && item_ready) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

endmodule

### rtl/iitc_exec.sv
// controller state and the single-pass update for one item
module iitc_exec #(
  parameter int COUNTER_COUNT = iitc_pkg::DEF_COUNTER_COUNT,
  parameter int COUNTER_BITS  = iitc_pkg::DEF_COUNTER_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  iitc_pkg::item_t  item_q,
  output iitc_pkg::result_t res
);

  localparam int CntW = COUNTER_BITS;
  localparam int BusW = iitc_pkg::BUS_COUNTER_BITS;

  logic [15:0]     irq_pending,     irq_pending_next;
  logic [15:0]     irq_enable,      irq_enable_next;
  logic [7:0]      firq_pending,    firq_pending_next;
  logic [7:0]      firq_enable,     firq_enable_next;
  logic [5:0]      control_written, control_written_next;
  logic [5:0]      control_inputs,  control_inputs_next;
  logic [7:0]      received_byte,   received_byte_next;
  logic [CntW-1:0] reload_value    [COUNTER_COUNT];
  logic [CntW-1:0] reload_value_next [COUNTER_COUNT];
  logic [CntW-1:0] current_count   [COUNTER_COUNT];
  logic [CntW-1:0] current_count_next [COUNTER_COUNT];
  logic [CntW-1:0] snapshot_count  [COUNTER_COUNT];
  logic [CntW-1:0] snapshot_count_next [COUNTER_COUNT];
  logic            counter_running [COUNTER_COUNT];
  logic            counter_running_next [COUNTER_COUNT];

  logic [4:0]      reg_sel;
  logic [7:0]      rd;
  logic            tx_v;
  logic [7:0]      tx_b;

  assign reg_sel = item_q.reg_offset[6:2];

  // decode the item and form next state plus result fields
  always_comb begin
    logic [BusW-1:0] wide;
    logic [7:0]      pend_shown;
    wide                 = '0;
    pend_shown           = irq_pending[7:0] | iitc_pkg::IRQ_ALWAYS;
    irq_pending_next     = irq_pending;
    irq_enable_next      = irq_enable;
    firq_pending_next    = firq_pending;
    firq_enable_next     = firq_enable;
    control_written_next = control_written;
    control_inputs_next  = control_inputs;
    received_byte_next   = received_byte;
    for (int k = 0; k < COUNTER_COUNT; k++) begin
      reload_value_next[k]    = reload_value[k];
      current_count_next[k]   = current_count[k];
      snapshot_count_next[k]  = snapshot_count[k];
      counter_running_next[k] = counter_running[k];
    end
    rd   = '0;
    tx_v = 1'b0;
    tx_b = '0;

    if (fire) begin
      case (item_q.opcode)
        // bus read
        iitc_pkg::OP_READ: begin
          case (reg_sel) inside
            iitc_pkg::REG_CTRL: begin
              rd = {irq_pending[3:2], control_inputs};
            end
            iitc_pkg::REG_SERIAL: begin
              rd = received_byte;
              irq_pending_next[iitc_pkg::IRQ_RX] = 1'b0;
            end
            iitc_pkg::REG_IRQA_STATUS: rd = pend_shown;
            iitc_pkg::REG_IRQA_REQ:    rd = pend_shown & irq_enable[7:0];
            iitc_pkg::REG_IRQA_MASK:   rd = irq_enable[7:0];
            iitc_pkg::REG_IRQB_STATUS: rd = irq_pending[15:8];
            iitc_pkg::REG_IRQB_REQ:    rd = irq_pending[15:8] & irq_enable[15:8];
            iitc_pkg::REG_IRQB_MASK:   rd = irq_enable[15:8];
            iitc_pkg::REG_FIRQ_STATUS: rd = firq_pending;
            iitc_pkg::REG_FIRQ_REQ:    rd = firq_pending & firq_enable;
            iitc_pkg::REG_FIRQ_MASK:   rd = firq_enable;
            [iitc_pkg::REG_CNT_FIRST:iitc_pkg::REG_CNT_LAST]: begin
              for (int k = 0; k < COUNTER_COUNT; k++) begin
                if (reg_sel[3:2] == 2'(k)) begin
                  wide = BusW'(snapshot_count[k]);
                  if (reg_sel[1:0] == iitc_pkg::CNT_LOW) begin
                    rd = wide[7:0];
                  end else if (reg_sel[1:0] == iitc_pkg::CNT_HIGH) begin
                    rd = wide[15:8];
                  end
                end
              end
            end
            default: rd = '0;
          endcase
        end

        // bus write
        iitc_pkg::OP_WRITE: begin
          case (reg_sel) inside
            iitc_pkg::REG_CTRL: begin
              control_written_next = item_q.write_data[5:0];
            end
            iitc_pkg::REG_SERIAL: begin
              tx_v = 1'b1;
              tx_b = item_q.write_data;
              irq_pending_next[iitc_pkg::IRQ_TX] = 1'b0;
            end
            iitc_pkg::REG_IRQA_REQ: begin
              irq_pending_next[7:0] = irq_pending[7:0]
                                    & ~(item_q.write_data & iitc_pkg::IRQ_LATCHED);
            end
            iitc_pkg::REG_IRQA_MASK: irq_enable_next[7:0]  = item_q.write_data;
            iitc_pkg::REG_IRQB_MASK: irq_enable_next[15:8] = item_q.write_data;
            iitc_pkg::REG_FIRQ_MASK: firq_enable_next      = item_q.write_data;
            [iitc_pkg::REG_CNT_FIRST:iitc_pkg::REG_CNT_LAST]: begin
              for (int k = 0; k < COUNTER_COUNT; k++) begin
                if (reg_sel[3:2] == 2'(k)) begin
                  wide = BusW'(reload_value[k]);
                  case (reg_sel[1:0])
                    iitc_pkg::CNT_LOW: begin
                      wide[7:0] = item_q.write_data;
                      reload_value_next[k] = wide[CntW-1:0];
                    end
                    iitc_pkg::CNT_HIGH: begin
                      wide[15:8] = item_q.write_data;
                      reload_value_next[k] = wide[CntW-1:0];
                    end
                    iitc_pkg::CNT_GO: begin
                      current_count_next[k]   = reload_value[k];
                      counter_running_next[k] = 1'b1;
                    end
                    default: snapshot_count_next[k] = current_count[k];
                  endcase
                end
              end
            end
            default: ;
          endcase
        end

        // timer tick: each counter is its own lane
        iitc_pkg::OP_TICK: begin
          for (int k = 0; k < COUNTER_COUNT; k++) begin
            if (counter_running[k] && (reload_value[k] != '0)) begin
              if (current_count[k] <= CntW'(1)) begin
                current_count_next[k] = reload_value[k];
                if (k == 0) irq_pending_next[iitc_pkg::IRQ_TIMER0] = 1'b1;
                if (k == 1) irq_pending_next[iitc_pkg::IRQ_TIMER1] = 1'b1;
              end else begin
                current_count_next[k] = current_count[k] - CntW'(1);
              end
            end
          end
        end

        // pin level change
        iitc_pkg::OP_PIN: begin
          case (item_q.pin_select) inside
            iitc_pkg::PIN_IL0: begin
              irq_pending_next[iitc_pkg::IRQ_IL0]    = !item_q.pin_level;
              firq_pending_next[iitc_pkg::FIRQ_IL0]  = !item_q.pin_level;
            end
            [iitc_pkg::PIN_IL1:iitc_pkg::PIN_IL5]: begin
              irq_pending_next[4'(item_q.pin_select + 5'd8)] = !item_q.pin_level;
            end
            [iitc_pkg::PIN_IL6:iitc_pkg::PIN_IL7]: begin
              irq_pending_next[4'(item_q.pin_select - iitc_pkg::PIN_IL6)] =
                !item_q.pin_level;
            end
            [iitc_pkg::PIN_FH0:iitc_pkg::PIN_FH1]: begin
              firq_pending_next[3'(item_q.pin_select - iitc_pkg::PIN_FH0)] =
                item_q.pin_level;
            end
            iitc_pkg::PIN_FL: begin
              firq_pending_next[iitc_pkg::FIRQ_FL] = !item_q.pin_level;
            end
            [iitc_pkg::PIN_C0:iitc_pkg::PIN_C5]: begin
              control_inputs_next[3'(item_q.pin_select - iitc_pkg::PIN_C0)] =
                item_q.pin_level;
              firq_pending_next = (firq_pending & ~iitc_pkg::CTRL_FIRQ)
                                | ({2'b00, control_inputs_next} & iitc_pkg::CTRL_FIRQ);
            end
            default: ;
          endcase
        end

        iitc_pkg::OP_POWER: irq_pending_next[iitc_pkg::IRQ_POWER] = 1'b1;

        iitc_pkg::OP_RX: begin
          received_byte_next = item_q.rx_byte;
          irq_pending_next[iitc_pkg::IRQ_RX] = 1'b1;
        end

        default: ;
      endcase
    end
  end

  // result fields reflect state after the item
  always_comb begin
    res.read_data        = rd;
    res.irq_line         = ((irq_pending_next | {8'h00, iitc_pkg::IRQ_ALWAYS})
                            & irq_enable_next) != '0;
    res.firq_line        = (firq_pending_next & firq_enable_next) != '0;
    res.control_pins_out = control_written_next & iitc_pkg::CTRL_BITS;
    res.tx_valid         = tx_v;
    res.tx_byte          = tx_b;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      irq_pending     <= '0;
      irq_enable      <= '0;
      firq_pending    <= '0;
      firq_enable     <= '0;
      control_written <= iitc_pkg::CTRL_BITS;
      control_inputs  <= iitc_pkg::CTRL_BITS;
      received_byte   <= '0;
      for (int k = 0; k < COUNTER_COUNT; k++) begin
        reload_value[k]    <= '0;
        current_count[k]   <= '0;
        snapshot_count[k]  <= '0;
        counter_running[k] <= 1'b0;
      end
    end else begin
      irq_pending     <= irq_pending_next;
      irq_enable      <= irq_enable_next;
      firq_pending    <= firq_pending_next;
      firq_enable     <= firq_enable_next;
      control_written <= control_written_next;
      control_inputs  <= control_inputs_next;
      received_byte   <= received_byte_next;
      for (int k = 0; k < COUNTER_COUNT; k++) begin
        reload_value[k]    <= reload_value_next[k];
        current_count[k]   <= current_count_next[k];
        snapshot_count[k]  <= snapshot_count_next[k];
        counter_running[k] <= counter_running_next[k];
      end
    end
  end

endmodule

### rtl/iitc_out_stage.sv
// result register: holds one finished result until the consumer takes the transfer
module iitc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  iitc_pkg::result_t res,
  output logic              advance,
  output logic              result_valid,
  input  logic              result_ready,
  output iitc_pkg::result_t result
);

  // the register frees up when empty or when its transfer completes
  assign advance = !result_valid || result_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (load) begin
      result <= res;
    end
  end

endmodule

### rtl/io_interrupt_timer_controller_core.sv
// top level of the i/o interrupt and timer controller
// a result passes the input register and then the result register before it is valid
// throughput: one item per cycle unless stalled; the register file update is one combinational pass
// item_ready drops only while a held result waits and the input register is full
// reset (rst, synchronous): irq/firq status and masks, counters and serial byte clear,
// control port and control inputs go to all ones, both stages empty
module io_interrupt_timer_controller_core #(
  parameter int COUNTER_COUNT = iitc_pkg::DEF_COUNTER_COUNT,
  parameter int COUNTER_BITS  = iitc_pkg::DEF_COUNTER_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  iitc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output iitc_pkg::result_t result
);

  logic              advance;
  logic              fire;
  iitc_pkg::item_t   item_q;
  iitc_pkg::result_t res;

  // input register
  iitc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .advance    (advance),
    .fire       (fire),
    .item_q     (item_q)
  );

  // state and update logic
  iitc_exec #(
    .COUNTER_COUNT (COUNTER_COUNT),
    .COUNTER_BITS  (COUNTER_BITS)
  ) u_exec (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item_q (item_q),
    .res    (res)
  );

  // result register
  iitc_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (fire),
    .res          (res),
    .advance      (advance),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

### rtl/iitc_checker.sv
// port-level checks for the interrupt and timer controller, bound to the top level
`include "io_interrupt_timer_controller_core_defines.svh"

module iitc_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input iitc_pkg::result_t result
);

  // a stalled result stays valid and unchanged
  `IITC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

  // a new result appears only after an earlier item transfer
  `IITC_ASSERT_NOW(a_result_after_item, $rose(result_valid), $past(item_valid && item_ready, 2))

  // input back-pressure only while the result register is stalled
  `IITC_ASSERT_NOW(a_ready_only_stalled, !item_ready, result_valid && !result_ready)

  // both stages come out of reset empty
  `IITC_ASSERT_NOW(a_reset_empty, $past(rst), !result_valid && item_ready)

endmodule

bind io_interrupt_timer_controller_core iitc_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

### test/tb_io_interrupt_timer_controller_core.sv
// testbench for the i/o interrupt and timer controller: predicted results checked per transfer
module tb_io_interrupt_timer_controller_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_COUNTERS = iitc_pkg::DEF_COUNTER_COUNT;
  localparam int CNT_BITS = iitc_pkg::DEF_COUNTER_BITS;
  localparam logic [15:0] CNT_MASK = 16'((32'd1 << CNT_BITS) - 1);
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  // opcodes and pin selects the block must ignore
  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam logic [4:0] PIN_NONE_LO = 5'd17;
  localparam logic [4:0] PIN_NONE_HI = 5'd31;

  logic              clk;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  iitc_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  iitc_pkg::result_t result;

  // predicted controller state
  logic [15:0] irq_pend;
  logic [15:0] irq_en;
  logic [7:0]  firq_pend;
  logic [7:0]  firq_en;
  logic [5:0]  ctrl_wr;
  logic [5:0]  ctrl_in;
  logic [7:0]  rx_hold;
  logic [15:0] reload_val [NUM_COUNTERS];
  logic [15:0] cur_cnt [NUM_COUNTERS];
  logic [15:0] snap_cnt [NUM_COUNTERS];
  logic        cnt_run [NUM_COUNTERS];

  iitc_pkg::result_t expected_results [$];
  int      errors = 0;
  int      items_sent = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;
  int      quiet_cycles = 0;

  io_interrupt_timer_controller_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // state of the controller right after reset
  task automatic clear_prediction();
    irq_pend = '0;
    irq_en = '0;
    firq_pend = '0;
    firq_en = '0;
    ctrl_wr = iitc_pkg::CTRL_BITS;
    ctrl_in = iitc_pkg::CTRL_BITS;
    rx_hold = '0;
    for (int k = 0; k < NUM_COUNTERS; k++) begin
      reload_val[k] = '0;
      cur_cnt[k] = '0;
      snap_cnt[k] = '0;
      cnt_run[k] = 1'b0;
    end
  endtask

  // apply one item to the predicted state and return the result it causes
  function automatic iitc_pkg::result_t predict_result(iitc_pkg::item_t it);
    iitc_pkg::result_t r;
    logic [4:0]  rsel;
    logic [15:0] shown;
    logic [7:0]  d;
    logic [4:0]  sel;
    logic        lvl;
    int          t;
    r = '0;
    rsel = it.reg_offset[6:2];
    d = it.write_data;
    sel = it.pin_select;
    lvl = it.pin_level;
    shown = irq_pend | {8'h00, iitc_pkg::IRQ_ALWAYS};
    t = (int'(rsel) - int'(iitc_pkg::REG_CNT_FIRST)) / 4;
    case (it.opcode)
      iitc_pkg::OP_READ: begin
        if (rsel >= iitc_pkg::REG_CNT_FIRST) begin
          if (t < NUM_COUNTERS) begin
            if (rsel[1:0] == iitc_pkg::CNT_LOW) r.read_data = snap_cnt[t][7:0];
            else if (rsel[1:0] == iitc_pkg::CNT_HIGH) r.read_data = snap_cnt[t][15:8];
          end
        end else begin
          case (rsel)
            iitc_pkg::REG_CTRL: begin
              r.read_data = {2'b00, ctrl_in}
                          | 8'((irq_pend[7:0] & iitc_pkg::CTRL_IRQ_SRC) << 4);
            end
            iitc_pkg::REG_SERIAL: begin
              r.read_data = rx_hold;
              irq_pend[iitc_pkg::IRQ_RX] = 1'b0;
            end
            iitc_pkg::REG_IRQA_STATUS: r.read_data = shown[7:0];
            iitc_pkg::REG_IRQA_REQ: r.read_data = shown[7:0] & irq_en[7:0];
            iitc_pkg::REG_IRQA_MASK: r.read_data = irq_en[7:0];
            iitc_pkg::REG_IRQB_STATUS: r.read_data = shown[15:8];
            iitc_pkg::REG_IRQB_REQ: r.read_data = shown[15:8] & irq_en[15:8];
            iitc_pkg::REG_IRQB_MASK: r.read_data = irq_en[15:8];
            iitc_pkg::REG_FIRQ_STATUS: r.read_data = firq_pend;
            iitc_pkg::REG_FIRQ_REQ: r.read_data = firq_pend & firq_en;
            iitc_pkg::REG_FIRQ_MASK: r.read_data = firq_en;
            default: ;
          endcase
        end
      end
      iitc_pkg::OP_WRITE: begin
        if (rsel >= iitc_pkg::REG_CNT_FIRST) begin
          if (t < NUM_COUNTERS) begin
            case (rsel[1:0])
              iitc_pkg::CNT_LOW: reload_val[t] = {reload_val[t][15:8], d} & CNT_MASK;
              iitc_pkg::CNT_HIGH: reload_val[t] = {d, reload_val[t][7:0]} & CNT_MASK;
              iitc_pkg::CNT_GO: begin
                cur_cnt[t] = reload_val[t];
                cnt_run[t] = 1'b1;
              end
              default: snap_cnt[t] = cur_cnt[t];
            endcase
          end
        end else begin
          case (rsel)
            iitc_pkg::REG_CTRL: ctrl_wr = d[5:0];
            iitc_pkg::REG_SERIAL: begin
              r.tx_valid = 1'b1;
              r.tx_byte = d;
              irq_pend[iitc_pkg::IRQ_TX] = 1'b0;
            end
            iitc_pkg::REG_IRQA_REQ: begin
              irq_pend[7:0] = irq_pend[7:0] & ~(d & iitc_pkg::IRQ_LATCHED);
            end
            iitc_pkg::REG_IRQA_MASK: irq_en[7:0] = d;
            iitc_pkg::REG_IRQB_MASK: irq_en[15:8] = d;
            iitc_pkg::REG_FIRQ_MASK: firq_en = d;
            default: ;
          endcase
        end
      end
      iitc_pkg::OP_TICK: begin
        for (int k = 0; k < NUM_COUNTERS; k++) begin
          if (cnt_run[k] && reload_val[k] != '0) begin
            if (cur_cnt[k] <= 16'd1) begin
              // wrap: reload, timers 0 and 1 raise their interrupts
              cur_cnt[k] = reload_val[k];
              if (k == 0) irq_pend[iitc_pkg::IRQ_TIMER0] = 1'b1;
              else if (k == 1) irq_pend[iitc_pkg::IRQ_TIMER1] = 1'b1;
            end else begin
              cur_cnt[k] = (cur_cnt[k] - 16'd1) & CNT_MASK;
            end
          end
        end
      end
      iitc_pkg::OP_PIN: begin
        if (sel == iitc_pkg::PIN_IL0) begin
          irq_pend[iitc_pkg::IRQ_IL0] = ~lvl;
          firq_pend[iitc_pkg::FIRQ_IL0] = ~lvl;
        end else if (sel <= iitc_pkg::PIN_IL5) begin
          irq_pend[iitc_pkg::IRQ_IL0 + int'(sel)] = ~lvl;
        end else if (sel <= iitc_pkg::PIN_IL7) begin
          irq_pend[int'(sel) - int'(iitc_pkg::PIN_IL6)] = ~lvl;
        end else if (sel <= iitc_pkg::PIN_FH1) begin
          firq_pend[int'(sel) - int'(iitc_pkg::PIN_FH0)] = lvl;
        end else if (sel == iitc_pkg::PIN_FL) begin
          firq_pend[iitc_pkg::FIRQ_FL] = ~lvl;
        end else if (sel <= iitc_pkg::PIN_C5) begin
          // control inputs C3-C5 mirror into firq status
          ctrl_in[int'(sel) - int'(iitc_pkg::PIN_C0)] = lvl;
          firq_pend = (firq_pend & ~iitc_pkg::CTRL_FIRQ)
                    | ({2'b00, ctrl_in} & iitc_pkg::CTRL_FIRQ);
        end
      end
      iitc_pkg::OP_POWER: irq_pend[iitc_pkg::IRQ_POWER] = 1'b1;
      iitc_pkg::OP_RX: begin
        rx_hold = it.rx_byte;
        irq_pend[iitc_pkg::IRQ_RX] = 1'b1;
      end
      default: ;
    endcase
    r.irq_line = |((irq_pend | {8'h00, iitc_pkg::IRQ_ALWAYS}) & irq_en);
    r.firq_line = |(firq_pend & firq_en);
    r.control_pins_out = ctrl_wr;
    return r;
  endfunction

  // one item transfer, with random sender gaps ahead of it
  task automatic send_item(iitc_pkg::item_t it);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    expected_results.push_back(predict_result(it));
    items_sent++;
  endtask

  // item with the given opcode, every other field random
  function automatic iitc_pkg::item_t mk_item(logic [2:0] op);
    iitc_pkg::item_t it;
    it = iitc_pkg::item_t'($urandom);
    it.opcode = op;
    return it;
  endfunction

  function automatic logic [4:0] cnt_reg(int t, logic [1:0] sub);
    return 5'(int'(iitc_pkg::REG_CNT_FIRST) + 4 * t + int'(sub));
  endfunction

  task automatic do_read(logic [4:0] r);
    iitc_pkg::item_t it;
    it = mk_item(iitc_pkg::OP_READ);
    it.reg_offset = {r, 2'($urandom)};
    send_item(it);
  endtask

  task automatic do_write(logic [4:0] r, logic [7:0] d);
    iitc_pkg::item_t it;
    it = mk_item(iitc_pkg::OP_WRITE);
    it.reg_offset = {r, 2'($urandom)};
    it.write_data = d;
    send_item(it);
  endtask

  task automatic do_pin(logic [4:0] sel, logic lvl);
    iitc_pkg::item_t it;
    it = mk_item(iitc_pkg::OP_PIN);
    it.pin_select = sel;
    it.pin_level = lvl;
    send_item(it);
  endtask

  // register index biased toward the mapped registers
  function automatic logic [4:0] pick_reg();
    case ($urandom_range(15))
      0: return iitc_pkg::REG_CTRL;
      1: return iitc_pkg::REG_SERIAL;
      2: return iitc_pkg::REG_IRQA_STATUS;
      3: return iitc_pkg::REG_IRQA_REQ;
      4: return iitc_pkg::REG_IRQA_MASK;
      5: return iitc_pkg::REG_IRQB_STATUS;
      6: return iitc_pkg::REG_IRQB_REQ;
      7: return iitc_pkg::REG_IRQB_MASK;
      8: return iitc_pkg::REG_FIRQ_STATUS;
      9: return iitc_pkg::REG_FIRQ_REQ;
      10: return iitc_pkg::REG_FIRQ_MASK;
      11, 12: return cnt_reg($urandom_range(NUM_COUNTERS - 1), 2'($urandom));
      default: return 5'($urandom);
    endcase
  endfunction

  // random item over all opcodes, pins and registers
  function automatic iitc_pkg::item_t random_mix_item();
    iitc_pkg::item_t it;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 25) it = mk_item(iitc_pkg::OP_READ);
    else if (pick < 52) it = mk_item(iitc_pkg::OP_WRITE);
    else if (pick < 64) it = mk_item(iitc_pkg::OP_TICK);
    else if (pick < 86) it = mk_item(iitc_pkg::OP_PIN);
    else if (pick < 90) it = mk_item(iitc_pkg::OP_POWER);
    else if (pick < 96) it = mk_item(iitc_pkg::OP_RX);
    else it = mk_item($urandom_range(1) ? OP_UNUSED_HI : OP_UNUSED_LO);
    if ($urandom_range(3) != 0) it.reg_offset = {pick_reg(), 2'($urandom)};
    if ($urandom_range(7) != 0) begin
      it.pin_select = 5'($urandom_range(int'(iitc_pkg::PIN_C5)));
    end
    return it;
  endfunction

  // extremes of the fields, each opcode and the named corner cases
  task automatic test_directed();
    iitc_pkg::item_t it;
    do_read(iitc_pkg::REG_CTRL);
    do_write(iitc_pkg::REG_IRQA_MASK, 8'hFF);
    do_write(iitc_pkg::REG_IRQB_MASK, 8'hFF);
    do_write(iitc_pkg::REG_FIRQ_MASK, 8'hFF);
    send_item(mk_item(iitc_pkg::OP_POWER));
    it = mk_item(iitc_pkg::OP_RX);
    it.rx_byte = 8'hFF;
    send_item(it);
    do_read(iitc_pkg::REG_SERIAL);
    do_write(iitc_pkg::REG_SERIAL, 8'hFF);
    do_write(iitc_pkg::REG_IRQA_REQ, 8'hFF);
    do_write(iitc_pkg::REG_CTRL, 8'h00);
    do_pin(iitc_pkg::PIN_IL0, 1'b0);
    do_pin(iitc_pkg::PIN_FH0, 1'b1);
    do_pin(iitc_pkg::PIN_FL, 1'b0);
    do_pin(iitc_pkg::PIN_C0 + 5'd3, 1'b0);
    do_pin(PIN_NONE_LO, 1'b0);
    do_pin(PIN_NONE_HI, 1'b1);
    send_item(mk_item(OP_UNUSED_LO));
    send_item(mk_item(OP_UNUSED_HI));
    // counter 0 with reload 2 wraps on the second tick
    do_write(cnt_reg(0, iitc_pkg::CNT_LOW), 8'd2);
    do_write(cnt_reg(0, iitc_pkg::CNT_HIGH), 8'd0);
    do_write(cnt_reg(0, iitc_pkg::CNT_GO), 8'h00);
    repeat (3) send_item(mk_item(iitc_pkg::OP_TICK));
    do_write(cnt_reg(0, iitc_pkg::CNT_LATCH), 8'h00);
    do_read(cnt_reg(0, iitc_pkg::CNT_LOW));
    // counter 3 started with zero reload holds
    do_write(cnt_reg(NUM_COUNTERS - 1, iitc_pkg::CNT_GO), 8'h00);
    send_item(mk_item(iitc_pkg::OP_TICK));
    do_read(iitc_pkg::REG_IRQA_STATUS);
    do_read(iitc_pkg::REG_IRQB_REQ);
  endtask

  // program, start and tick counters, then latch and read back
  task automatic test_timer_runs(int n_items);
    int         start;
    int         t;
    logic [7:0] lo;
    logic [7:0] hi;
    start = items_sent;
    while (items_sent - start < n_items) begin
      t = ($urandom_range(9) < 7) ? $urandom_range(1) : $urandom_range(NUM_COUNTERS - 1);
      lo = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(6));
      hi = ($urandom_range(7) == 0) ? 8'($urandom) : 8'h00;
      if ($urandom_range(1)) begin
        do_write(cnt_reg(t, iitc_pkg::CNT_LOW), lo);
        do_write(cnt_reg(t, iitc_pkg::CNT_HIGH), hi);
      end else begin
        do_write(cnt_reg(t, iitc_pkg::CNT_HIGH), hi);
        do_write(cnt_reg(t, iitc_pkg::CNT_LOW), lo);
      end
      if ($urandom_range(3) == 0) do_write(iitc_pkg::REG_IRQA_MASK, 8'($urandom));
      do_write(cnt_reg(t, iitc_pkg::CNT_GO), 8'($urandom));
      repeat ($urandom_range(12)) begin
        if ($urandom_range(9) == 0) send_item(random_mix_item());
        send_item(mk_item(iitc_pkg::OP_TICK));
      end
      do_write(cnt_reg(t, iitc_pkg::CNT_LATCH), 8'($urandom));
      do_read(cnt_reg(t, iitc_pkg::CNT_LOW));
      do_read(cnt_reg(t, iitc_pkg::CNT_HIGH));
      do_read($urandom_range(1) ? iitc_pkg::REG_IRQA_STATUS : iitc_pkg::REG_IRQA_REQ);
      if ($urandom_range(2) == 0) do_write(iitc_pkg::REG_IRQA_REQ, 8'($urandom));
    end
  endtask

  task automatic test_random_mix(int n_items);
    repeat (n_items) send_item(random_mix_item());
  endtask

  // sender holds off until every expected result has come back
  task automatic test_drain_pause();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // receiver stalls
  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic note_mismatch(string field, int unsigned want, int unsigned got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch %s: expected 0x%0h, got 0x%0h", field, want, got);
  endtask

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    iitc_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("result transfer with nothing expected: 0x%0h", result);
      end else begin
        want = expected_results.pop_front();
        if (result.read_data !== want.read_data)
          note_mismatch("read_data", want.read_data, result.read_data);
        if (result.irq_line !== want.irq_line)
          note_mismatch("irq_line", want.irq_line, result.irq_line);
        if (result.firq_line !== want.firq_line)
          note_mismatch("firq_line", want.firq_line, result.firq_line);
        if (result.control_pins_out !== want.control_pins_out)
          note_mismatch("control_pins_out", want.control_pins_out, result.control_pins_out);
        if (result.tx_valid !== want.tx_valid)
          note_mismatch("tx_valid", want.tx_valid, result.tx_valid);
        if (result.tx_byte !== want.tx_byte)
          note_mismatch("tx_byte", want.tx_byte, result.tx_byte);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_io_interrupt_timer_controller_core: FAIL");
        $finish;
      end
    end
  end

  initial begin
    clear_prediction();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    // idle phases: none, sender, receiver, both
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 87 : (phase == 3) ? 35 : 0;
      stall_pct = (phase == 2) ? 87 : (phase == 3) ? 35 : 0;
      test_timer_runs(80);
      if (phase == 1) test_drain_pause();
      test_random_mix(80);
    end
    test_drain_pause();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_io_interrupt_timer_controller_core: PASS");
    end else begin
      $display("tb_io_interrupt_timer_controller_core: FAIL");
    end
    $finish;
  end

endmodule
